>>> rtl/gjinv_pkg.sv
// shared types and constants for the gauss-jordan inverter
package gjinv_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ORDER_W = 4;

  typedef enum logic [4:0] {
    S_IDLE, S_ID,
    S_PV_RD, S_PV_CK, S_SR_RD, S_SR_CK,
    S_CP_RD, S_CP_WR, S_SW_RD, S_SW_WR, S_SW_WJ,
    S_EL_CHK, S_EL_DV, S_EL_DW, S_EL_RD, S_EL_WT, S_EL_WR,
    S_DG_RD, S_DG_CK,
    S_OT_DRD, S_OT_DLD, S_OT_RD, S_OT_DV, S_OT_DW,
    S_SG
  } state_t;

  typedef enum logic [2:0] {
    WS_IN, WS_ID, WS_PIV, WS_RD, WS_ELIM, WS_ZERO
  } wsel_t;

  typedef enum logic {
    DS_ELIM, DS_FIN
  } dsel_t;

  typedef struct packed {
    logic  mem_we;
    logic  mem_re;
    wsel_t wsel;
    logic  id_one;
    logic  piv_we;
    logic  mul_en;
    logic  fm_en;
    logic  div_start;
    dsel_t dsel;
    logic  m_ld;
    logic  d_ld;
    logic  out_we;
    logic  out_sing;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic div_done;
  } sta_t;

endpackage

>>> rtl/gjinv_div.sv
// radix-2 signed fixed-point divider with saturation, one quotient bit per cycle
module gjinv_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [gjinv_pkg::DATA_W-1:0] num,
  input  logic signed [gjinv_pkg::DATA_W-1:0] den,
  output logic                             done,
  output logic signed [gjinv_pkg::DATA_W-1:0] quot
);
  import gjinv_pkg::*;

  localparam int unsigned NW = DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NW);

  logic              run_r, fin_r, done_r, neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NW-1:0]     dvd_r;
  logic [DATA_W:0]   rem_r;
  logic [DATA_W-1:0] dmag_r;
  logic signed [DATA_W-1:0] q_r;

  logic [DATA_W:0]   trial;
  logic              ge;
  logic [DATA_W-1:0] nmag;
  logic signed [DATA_W-1:0] q_sat;
  logic [NW-1:0]     qneg;

  assign nmag  = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
  assign trial = {rem_r[DATA_W-1:0], dvd_r[NW-1]};
  assign ge    = trial >= {1'b0, dmag_r};
  assign qneg  = NW'(0) - dvd_r;

  always_comb begin
    if (neg_r) begin
      if (dvd_r > (NW'(1) << (DATA_W - 1))) begin
        q_sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        q_sat = qneg[DATA_W-1:0];
      end
    end else begin
      if (dvd_r > ((NW'(1) << (DATA_W - 1)) - NW'(1))) begin
        q_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        q_sat = dvd_r[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        fin_r  <= 1'b0;
        cnt_r  <= '0;
        dvd_r  <= {nmag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        dmag_r <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
        neg_r  <= num[DATA_W-1] ^ den[DATA_W-1];
      end else if (run_r) begin
        rem_r <= ge ? (trial - {1'b0, dmag_r}) : trial;
        dvd_r <= {dvd_r[NW-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NW - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        q_r    <= q_sat;
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> rtl/gjinv_dp.sv
// datapath: augmented store, pivot row buffer, multiplier, divider and result registers
module gjinv_dp #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned RW        = 3,
  parameter int unsigned CW        = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gjinv_pkg::cmd_t                     cmd,
  input  logic [RW-1:0]                       row,
  input  logic [CW-1:0]                       col,
  input  logic signed [gjinv_pkg::DATA_W-1:0] in_element_value,
  output gjinv_pkg::sta_t                     sta,
  output logic                                out_valid,
  output logic signed [gjinv_pkg::DATA_W-1:0] out_inverse_value,
  output logic                                out_singular,
  output logic                                out_last_result
);
  import gjinv_pkg::*;

  localparam int unsigned DEPTH = 1 << (RW + CW);
  localparam int unsigned PDEP  = 1 << CW;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] piv_r [PDEP];
  logic signed [DATA_W-1:0] rdata_r, m_r, d_r, fm_r;
  logic signed [63:0]       prod_r;
  logic                     ov_r, os_r, ol_r;
  logic signed [DATA_W-1:0] ov_val_r;

  logic [RW+CW-1:0]         addr;
  logic signed [DATA_W-1:0] wdata, piv_sel, div_num, div_den, div_q, neg_rd;
  logic signed [63:0]       prnd, psh;
  logic                     div_done;

  assign addr    = {row, col};
  assign piv_sel = piv_r[col];
  assign neg_rd  = (rdata_r == {1'b1, {(DATA_W-1){1'b0}}}) ?
                   {1'b0, {(DATA_W-1){1'b1}}} : -rdata_r;
  assign prnd    = prod_r + (64'sd1 <<< (FRAC_BITS - 1));
  assign psh     = prnd >>> FRAC_BITS;

  always_comb begin
    case (cmd.wsel)
      WS_IN:   wdata = in_element_value;
      WS_ID:   wdata = cmd.id_one ? (DATA_W'(1) << FRAC_BITS) : '0;
      WS_PIV:  wdata = piv_sel;
      WS_RD:   wdata = rdata_r;
      WS_ELIM: wdata = sat32(64'(rdata_r) + 64'(fm_r));
      WS_ZERO: wdata = '0;
      default: wdata = '0;
    endcase
  end

  always_comb begin
    case (cmd.dsel)
      DS_ELIM: begin
        div_num = neg_rd;
        div_den = piv_sel;
      end
      DS_FIN: begin
        div_num = rdata_r;
        div_den = d_r;
      end
      default: begin
        div_num = rdata_r;
        div_den = d_r;
      end
    endcase
  end

  gjinv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.piv_we) begin
      piv_r[col] <= rdata_r;
    end
    if (cmd.mul_en) begin
      prod_r <= 64'(m_r) * 64'(piv_sel);
    end
    if (cmd.fm_en) begin
      fm_r <= sat32(psh);
    end
    if (cmd.m_ld) begin
      m_r <= div_q;
    end
    if (cmd.d_ld) begin
      d_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cmd.out_we;
    end
    if (cmd.out_we) begin
      ov_val_r <= cmd.out_sing ? '0 : div_q;
      os_r     <= cmd.out_sing;
      ol_r     <= cmd.out_last;
    end
  end

  assign sta.rd_zero    = (rdata_r == '0);
  assign sta.div_done   = div_done;
  assign out_valid         = ov_r;
  assign out_inverse_value = ov_val_r;
  assign out_singular      = os_r;
  assign out_last_result   = ol_r;

endmodule

>>> rtl/gjinv_ctrl.sv
// controller: load counters, elimination sequencer and order register
module gjinv_ctrl #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned RW        = 3,
  parameter int unsigned CW        = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gjinv_pkg::ORDER_W-1:0] cfg_matrix_order,
  input  gjinv_pkg::sta_t              sta,
  output gjinv_pkg::cmd_t              cmd,
  output logic [RW-1:0]                row,
  output logic [CW-1:0]                col
);
  import gjinv_pkg::*;

  state_t              state_r, state_nxt;
  logic [ORDER_W-1:0]  order_r;
  logic [RW-1:0]       nm1;
  logic [RW-1:0]       i_r, i_nxt, j_r, j_nxt, r_r, r_nxt, lrow_r, lrow_nxt, lcol_r, lcol_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       kn;
  logic                kend_id, kend_row;

  always_comb begin
    if (order_r == '0) begin
      nm1 = '0;
    end else if (order_r > ORDER_W'(MAX_ORDER)) begin
      nm1 = RW'(MAX_ORDER - 1);
    end else begin
      nm1 = RW'(order_r - ORDER_W'(1));
    end
  end

  assign kn       = {1'b0, nm1} + CW'(1) + k_r;
  assign kend_id  = (k_r == {1'b0, nm1});
  assign kend_row = (k_r == {nm1, 1'b1});
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      order_r <= ORDER_W'(8);
      i_r     <= '0;
      j_r     <= '0;
      r_r     <= '0;
      k_r     <= '0;
      lrow_r  <= '0;
      lcol_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      r_r     <= r_nxt;
      k_r     <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_matrix_order;
        lrow_r  <= '0;
        lcol_r  <= '0;
      end else begin
        lrow_r <= lrow_nxt;
        lcol_r <= lcol_nxt;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    lrow_nxt  = lrow_r;
    lcol_nxt  = lcol_r;
    cmd       = '0;
    row       = i_r;
    col       = k_r;
    case (state_r)
      S_IDLE: begin
        row = lrow_r;
        col = {1'b0, lcol_r};
        if (start) begin
          cmd.mem_we = 1'b1;
          cmd.wsel   = WS_IN;
          if (lcol_r == nm1) begin
            lcol_nxt = '0;
            if (lrow_r == nm1) begin
              lrow_nxt  = '0;
              i_nxt     = '0;
              k_nxt     = '0;
              state_nxt = S_ID;
            end else begin
              lrow_nxt = lrow_r + RW'(1);
            end
          end else begin
            lcol_nxt = lcol_r + RW'(1);
          end
        end
      end
      S_ID: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_ID;
        cmd.id_one = (k_r == {1'b0, i_r});
        col        = kn;
        if (kend_id) begin
          k_nxt = '0;
          if (i_r == nm1) begin
            j_nxt     = '0;
            state_nxt = S_PV_RD;
          end else begin
            i_nxt = i_r + RW'(1);
          end
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_PV_RD: begin
        cmd.mem_re = 1'b1;
        row        = j_r;
        col        = {1'b0, j_r};
        state_nxt  = S_PV_CK;
      end
      S_PV_CK: begin
        if (!sta.rd_zero) begin
          r_nxt     = j_r;
          k_nxt     = '0;
          state_nxt = S_CP_RD;
        end else if (j_r == nm1) begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_SG;
        end else begin
          r_nxt     = j_r + RW'(1);
          state_nxt = S_SR_RD;
        end
      end
      S_SR_RD: begin
        cmd.mem_re = 1'b1;
        row        = r_r;
        col        = {1'b0, j_r};
        state_nxt  = S_SR_CK;
      end
      S_SR_CK: begin
        if (!sta.rd_zero) begin
          k_nxt     = '0;
          state_nxt = S_CP_RD;
        end else if (r_r == nm1) begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_SG;
        end else begin
          r_nxt     = r_r + RW'(1);
          state_nxt = S_SR_RD;
        end
      end
      S_CP_RD: begin
        cmd.mem_re = 1'b1;
        row        = r_r;
        state_nxt  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.piv_we = 1'b1;
        if (r_r != j_r) begin
          state_nxt = S_SW_RD;
        end else if (kend_row) begin
          i_nxt     = '0;
          state_nxt = S_EL_CHK;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_CP_RD;
        end
      end
      S_SW_RD: begin
        cmd.mem_re = 1'b1;
        row        = j_r;
        state_nxt  = S_SW_WR;
      end
      S_SW_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_RD;
        row        = r_r;
        state_nxt  = S_SW_WJ;
      end
      S_SW_WJ: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_PIV;
        row        = j_r;
        if (kend_row) begin
          i_nxt     = '0;
          state_nxt = S_EL_CHK;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_CP_RD;
        end
      end
      S_EL_CHK: begin
        col = {1'b0, j_r};
        if (i_r == j_r) begin
          if (i_r == nm1) begin
            if (j_r == nm1) begin
              i_nxt     = '0;
              state_nxt = S_DG_RD;
            end else begin
              j_nxt     = j_r + RW'(1);
              state_nxt = S_PV_RD;
            end
          end else begin
            i_nxt = i_r + RW'(1);
          end
        end else begin
          cmd.mem_re = 1'b1;
          state_nxt  = S_EL_DV;
        end
      end
      S_EL_DV: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = DS_ELIM;
        col           = {1'b0, j_r};
        state_nxt     = S_EL_DW;
      end
      S_EL_DW: begin
        if (sta.div_done) begin
          cmd.m_ld  = 1'b1;
          k_nxt     = '0;
          state_nxt = S_EL_RD;
        end
      end
      S_EL_RD: begin
        cmd.mem_re = 1'b1;
        cmd.mul_en = 1'b1;
        state_nxt  = S_EL_WT;
      end
      S_EL_WT: begin
        cmd.fm_en = 1'b1;
        state_nxt = S_EL_WR;
      end
      S_EL_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = (k_r == {1'b0, j_r}) ? WS_ZERO : WS_ELIM;
        if (kend_row) begin
          k_nxt = '0;
          if (i_r == nm1) begin
            if (j_r == nm1) begin
              i_nxt     = '0;
              state_nxt = S_DG_RD;
            end else begin
              j_nxt     = j_r + RW'(1);
              state_nxt = S_PV_RD;
            end
          end else begin
            i_nxt     = i_r + RW'(1);
            state_nxt = S_EL_CHK;
          end
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_EL_RD;
        end
      end
      S_DG_RD: begin
        cmd.mem_re = 1'b1;
        col        = {1'b0, i_r};
        state_nxt  = S_DG_CK;
      end
      S_DG_CK: begin
        if (sta.rd_zero) begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_SG;
        end else if (i_r == nm1) begin
          i_nxt     = '0;
          state_nxt = S_OT_DRD;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = S_DG_RD;
        end
      end
      S_OT_DRD: begin
        cmd.mem_re = 1'b1;
        col        = {1'b0, i_r};
        state_nxt  = S_OT_DLD;
      end
      S_OT_DLD: begin
        cmd.d_ld  = 1'b1;
        k_nxt     = '0;
        state_nxt = S_OT_RD;
      end
      S_OT_RD: begin
        cmd.mem_re = 1'b1;
        col        = kn;
        state_nxt  = S_OT_DV;
      end
      S_OT_DV: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = DS_FIN;
        state_nxt     = S_OT_DW;
      end
      S_OT_DW: begin
        if (sta.div_done) begin
          cmd.out_we   = 1'b1;
          cmd.out_last = (i_r == nm1) && kend_id;
          if (kend_id) begin
            k_nxt = '0;
            if (i_r == nm1) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + RW'(1);
              state_nxt = S_OT_DRD;
            end
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_OT_RD;
          end
        end
      end
      S_SG: begin
        cmd.out_we   = 1'b1;
        cmd.out_sing = 1'b1;
        cmd.out_last = (i_r == nm1) && kend_id;
        if (kend_id) begin
          k_nxt = '0;
          if (i_r == nm1) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + RW'(1);
          end
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/gauss_jordan_matrix_inverse_core.sv
// top level of the gauss-jordan matrix inverter
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | start, busy           | in_element_value
//  result   | out_valid (strobe)    | out_inverse_value, out_singular, out_last_result
//  config   | cfg_valid, cfg_ready  | cfg_matrix_order
//
// loading writes the elements row by row while start is high; after the n*n-th element
// busy stays high through: identity fill over n*n entries; per column a pivot search down
// the lower rows, then a copy of the pivot row over 2n entries (with a row swap where
// needed); per other row one divider pass plus an update over 2n entries; a diagonal
// check per row; per output row a diagonal load, each result one divider pass.
// reset is synchronous and clears control state only; results cannot be stalled.
module gauss_jordan_matrix_inverse_core #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [gjinv_pkg::DATA_W-1:0] in_element_value,
  output logic                                out_valid,
  output logic signed [gjinv_pkg::DATA_W-1:0] out_inverse_value,
  output logic                                out_singular,
  output logic                                out_last_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gjinv_pkg::ORDER_W-1:0]       cfg_matrix_order
);
  import gjinv_pkg::*;

  localparam int unsigned RW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned CW = RW + 1;

  cmd_t          cmd;
  sta_t          sta;
  logic [RW-1:0] row;
  logic [CW-1:0] col;

  gjinv_ctrl #(.MAX_ORDER(MAX_ORDER), .RW(RW), .CW(CW)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_matrix_order (cfg_matrix_order),
    .sta              (sta),
    .cmd              (cmd),
    .row              (row),
    .col              (col)
  );

  gjinv_dp #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS), .RW(RW), .CW(CW)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .row               (row),
    .col               (col),
    .in_element_value  (in_element_value),
    .sta               (sta),
    .out_valid         (out_valid),
    .out_inverse_value (out_inverse_value),
    .out_singular      (out_singular),
    .out_last_result   (out_last_result)
  );

endmodule

>>> rtl/gjinv_checker.sv
// port-level checks for the matrix inverter and their bind
module gjinv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic [31:0] out_inverse_value,
  input logic        out_singular,
  input logic        out_last_result
);

  a_beat_inside_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> busy)
    else $error("non-final result beat while idle");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result beat after final beat");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inverse_value == 32'd0)
    else $error("singular result carries nonzero value");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy)
    else $error("config accepted while busy");

endmodule

bind gauss_jordan_matrix_inverse_core gjinv_checker u_gjinv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .cfg_ready         (cfg_ready),
  .out_valid         (out_valid),
  .out_inverse_value (out_inverse_value),
  .out_singular      (out_singular),
  .out_last_result   (out_last_result)
);
